### src/msw_pkg.sv
`timescale 1ns / 1ps
// msw_pkg: shared types, codes and reset values of the motion stall watchdog
// depends on nothing

package msw_pkg;

    localparam int CFG_BITS     = 16;
    localparam int CFG_IDX_BITS = 2;
    localparam int JOINT_FIELDS = 6;
    localparam int MODE_BITS    = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_MOTION_EPSILON = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PLAN_TIMEOUT   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_EXEC_GRACE     = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STALL_TIMEOUT  = 2'd3;

    localparam logic [CFG_BITS-1:0] EPSILON_RESET       = 16'd66;
    localparam logic [CFG_BITS-1:0] PLAN_TIMEOUT_RESET  = 16'd1000;
    localparam logic [CFG_BITS-1:0] EXEC_GRACE_RESET    = 16'd200;
    localparam logic [CFG_BITS-1:0] STALL_TIMEOUT_RESET = 16'd300;

    // supervisor modes
    localparam logic [MODE_BITS-1:0] MODE_IDLE = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_PLAN = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_EXEC = 2'd2;

    // request kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_POLL  = 1'b1;

    // planner and execution status codes
    localparam logic [1:0] PHASE_PENDING = 2'd0;
    localparam logic [1:0] PHASE_OK      = 2'd1;
    localparam logic [1:0] PHASE_FAILED  = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_RUNNING = 2'd0;
    localparam logic [1:0] STATUS_SUCCESS = 2'd1;
    localparam logic [1:0] STATUS_FAILURE = 2'd2;

    // failure causes
    localparam logic [2:0] CAUSE_NONE         = 3'd0;
    localparam logic [2:0] CAUSE_PLAN_TIMEOUT = 3'd1;
    localparam logic [2:0] CAUSE_PLAN_FAILED  = 3'd2;
    localparam logic [2:0] CAUSE_EXEC_FAILED  = 3'd3;
    localparam logic [2:0] CAUSE_STALL        = 3'd4;
    localparam logic [2:0] CAUSE_NOT_ACTIVE   = 3'd5;

    typedef struct packed {
        logic [CFG_BITS-1:0] motion_epsilon;
        logic [CFG_BITS-1:0] plan_timeout_ticks;
        logic [CFG_BITS-1:0] exec_grace_ticks;
        logic [CFG_BITS-1:0] stall_timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] fail_cause;
        logic       start_exec;
        logic       stop_arm;
        logic       clear_targets;
    } t_result;

    // snapshot store control from the supervisor
    typedef struct packed {
        logic snap_we;
        logic have_we;
        logic have_val;
    } t_snap_ctrl;

endpackage

### src/motion_stall_watchdog.sv
`timescale 1ns / 1ps
// motion_stall_watchdog: top level, request and result registers around the supervisor
// depends on msw_pkg, msw_cfg_regs, msw_motion, msw_ctrl
//
//  channel   direction  handshake                 payload
//  request   in         i_in_valid / o_in_stall   kind, plan/exec status, joints
//  result    out        o_out_valid / i_out_stall status, cause, command pulses
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// one request per cycle sustained while the result side does not stall
// the request register feeds the supervisor logic, which loads the result register
// a waiting result blocks only once the request register is full: one more request is taken while it is held
// synchronous reset clears control state and restores the threshold defaults

module motion_stall_watchdog import msw_pkg::*; #(
    parameter int JOINT_COUNT = 6,
    parameter int TIMER_BITS  = 16,
    parameter int POS_BITS    = 20
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_kind,
    input  logic [1:0]                 i_plan_status,
    input  logic [1:0]                 i_exec_status,
    input  logic                       i_joints_valid,
    input  logic signed [POS_BITS-1:0] i_joint_a,
    input  logic signed [POS_BITS-1:0] i_joint_b,
    input  logic signed [POS_BITS-1:0] i_joint_c,
    input  logic signed [POS_BITS-1:0] i_joint_d,
    input  logic signed [POS_BITS-1:0] i_joint_e,
    input  logic signed [POS_BITS-1:0] i_joint_f,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [1:0]                 o_status,
    output logic [2:0]                 o_fail_cause,
    output logic                       o_start_exec,
    output logic                       o_stop_arm,
    output logic                       o_clear_targets,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [CFG_BITS-1:0]        i_cfg_data
);

    localparam int JOINT_USED = (JOINT_COUNT < JOINT_FIELDS) ? JOINT_COUNT : JOINT_FIELDS;

    logic                       r_in_valid;
    logic                       r_kind;
    logic [1:0]                 r_plan_status;
    logic [1:0]                 r_exec_status;
    logic                       r_joints_valid;
    logic signed [POS_BITS-1:0] r_joint [JOINT_FIELDS];
    logic signed [POS_BITS-1:0] w_joint_in [JOINT_FIELDS];
    logic signed [POS_BITS-1:0] w_joint_used [JOINT_USED];
    logic                       r_out_valid;
    t_result                    r_result;

    logic                 w_accept;
    logic                 w_fire;
    t_cfg                 w_cfg;
    t_result              w_result;
    t_snap_ctrl           w_snap;
    logic                 w_have_last;
    logic                 w_any_diff;
    logic [MODE_BITS-1:0] w_mode;

    assign w_joint_in[0] = i_joint_a;
    assign w_joint_in[1] = i_joint_b;
    assign w_joint_in[2] = i_joint_c;
    assign w_joint_in[3] = i_joint_d;
    assign w_joint_in[4] = i_joint_e;
    assign w_joint_in[5] = i_joint_f;

    for (genvar j = 0; j < JOINT_USED; j++) begin : g_used
        assign w_joint_used[j] = r_joint[j];
    end

    // a held request moves on when the result register is free or draining
    assign w_fire     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_fire;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind         <= i_kind;
            r_plan_status  <= i_plan_status;
            r_exec_status  <= i_exec_status;
            r_joints_valid <= i_joints_valid;
            for (int j = 0; j < JOINT_FIELDS; j++) begin
                r_joint[j] <= w_joint_in[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_result <= w_result;
        end
    end

    assign o_cfg_ready = !r_in_valid;

    msw_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    msw_motion #(
        .POS_BITS   (POS_BITS),
        .JOINT_USED (JOINT_USED)
    ) u_motion (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_joint     (w_joint_used),
        .i_epsilon   (w_cfg.motion_epsilon),
        .i_snap      (w_snap),
        .o_have_last (w_have_last),
        .o_any_diff  (w_any_diff)
    );

    msw_ctrl #(
        .TIMER_BITS (TIMER_BITS)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (w_fire),
        .i_kind         (r_kind),
        .i_plan_status  (r_plan_status),
        .i_exec_status  (r_exec_status),
        .i_joints_valid (r_joints_valid),
        .i_have_last    (w_have_last),
        .i_any_diff     (w_any_diff),
        .i_cfg          (w_cfg),
        .o_result       (w_result),
        .o_snap         (w_snap),
        .o_mode         (w_mode)
    );

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_result.status;
    assign o_fail_cause    = r_result.fail_cause;
    assign o_start_exec    = r_result.start_exec;
    assign o_stop_arm      = r_result.stop_arm;
    assign o_clear_targets = r_result.clear_targets;

    a_finish_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_result.status != STATUS_RUNNING) |=> (w_mode == MODE_IDLE))
        else $error("finished request did not return to idle");

    a_start_to_plan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_kind == KIND_START) |=> (w_mode == MODE_PLAN))
        else $error("start request did not enter planning");

    a_exec_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_result.start_exec) |=> (w_mode == MODE_EXEC && o_out_valid))
        else $error("execution launch lost");

    a_stall_held: assert property (@(posedge i_clk)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("request stalled with no result pending");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !r_in_valid))
        else $error("pipeline not empty after reset");

endmodule

### src/msw_cfg_regs.sv
`timescale 1ns / 1ps
// msw_cfg_regs: the four threshold registers behind the configuration write port
// depends on msw_pkg

module msw_cfg_regs import msw_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_we,
    input  logic [CFG_IDX_BITS-1:0] i_index,
    input  logic [CFG_BITS-1:0]     i_data,
    output t_cfg                    o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.motion_epsilon      <= EPSILON_RESET;
            r_cfg.plan_timeout_ticks  <= PLAN_TIMEOUT_RESET;
            r_cfg.exec_grace_ticks    <= EXEC_GRACE_RESET;
            r_cfg.stall_timeout_ticks <= STALL_TIMEOUT_RESET;
        end else if (i_we) begin
            unique case (i_index)
                CFG_MOTION_EPSILON: r_cfg.motion_epsilon      <= i_data;
                CFG_PLAN_TIMEOUT:   r_cfg.plan_timeout_ticks  <= i_data;
                CFG_EXEC_GRACE:     r_cfg.exec_grace_ticks    <= i_data;
                CFG_STALL_TIMEOUT:  r_cfg.stall_timeout_ticks <= i_data;
                default:            r_cfg <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### src/msw_motion.sv
`timescale 1ns / 1ps
// msw_motion: joint snapshot store and per-joint motion compare against epsilon
// depends on msw_pkg

module msw_motion import msw_pkg::*; #(
    parameter int POS_BITS   = 20,
    parameter int JOINT_USED = 6
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic signed [POS_BITS-1:0] i_joint [JOINT_USED],
    input  logic [CFG_BITS-1:0]        i_epsilon,
    input  t_snap_ctrl                 i_snap,
    output logic                       o_have_last,
    output logic                       o_any_diff
);

    localparam int MAG_BITS = (POS_BITS + 1 > CFG_BITS) ? POS_BITS + 1 : CFG_BITS;

    logic signed [POS_BITS-1:0] r_last [JOINT_USED];
    logic                       r_have_last;
    logic [JOINT_USED-1:0]      w_moved;

    always_comb begin
        logic signed [POS_BITS:0] diff;
        logic        [POS_BITS:0] mag;
        for (int j = 0; j < JOINT_USED; j++) begin
            diff = (POS_BITS + 1)'(i_joint[j]) - (POS_BITS + 1)'(r_last[j]);
            mag  = diff[POS_BITS] ? (POS_BITS + 1)'(-diff) : (POS_BITS + 1)'(diff);
            w_moved[j] = MAG_BITS'(mag) > MAG_BITS'(i_epsilon);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_last <= 1'b0;
        end else if (i_snap.have_we) begin
            r_have_last <= i_snap.have_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_snap.snap_we) begin
            for (int j = 0; j < JOINT_USED; j++) begin
                r_last[j] <= i_joint[j];
            end
        end
    end

    assign o_have_last = r_have_last;
    assign o_any_diff  = |w_moved;

endmodule

### src/msw_ctrl.sv
`timescale 1ns / 1ps
// msw_ctrl: supervisor mode, phase and progress timers, and result decision
// depends on msw_pkg

module msw_ctrl import msw_pkg::*; #(
    parameter int TIMER_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic                 i_kind,
    input  logic [1:0]           i_plan_status,
    input  logic [1:0]           i_exec_status,
    input  logic                 i_joints_valid,
    input  logic                 i_have_last,
    input  logic                 i_any_diff,
    input  t_cfg                 i_cfg,
    output t_result              o_result,
    output t_snap_ctrl           o_snap,
    output logic [MODE_BITS-1:0] o_mode
);

    localparam int CMP_BITS = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;

    logic [MODE_BITS-1:0]  r_mode,  n_mode;
    logic [TIMER_BITS-1:0] r_phase, n_phase;
    logic [TIMER_BITS-1:0] r_prog,  n_prog;
    t_result               w_res;
    t_snap_ctrl            w_snap;
    logic [TIMER_BITS-1:0] w_phase_tick;
    logic [TIMER_BITS-1:0] w_prog_tick;
    logic                  w_moved;

    function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] t);
        return (&t) ? t : t + TIMER_BITS'(1);
    endfunction

    assign w_phase_tick = sat_inc(r_phase);
    assign w_prog_tick  = sat_inc(r_prog);
    // first snapshot counts as motion, missing joints as none
    assign w_moved = i_joints_valid && (!i_have_last || i_any_diff);

    always_comb begin
        n_mode  = r_mode;
        n_phase = r_phase;
        n_prog  = r_prog;
        w_res   = '0;
        w_snap  = '0;
        if (i_kind == KIND_START) begin
            n_mode  = MODE_PLAN;
            n_phase = '0;
            n_prog  = '0;
        end else begin
            unique case (r_mode)
                MODE_PLAN: begin
                    n_phase = w_phase_tick;
                    if (CMP_BITS'(w_phase_tick) > CMP_BITS'(i_cfg.plan_timeout_ticks)) begin
                        w_res.status        = STATUS_FAILURE;
                        w_res.fail_cause    = CAUSE_PLAN_TIMEOUT;
                        w_res.clear_targets = 1'b1;
                        n_mode              = MODE_IDLE;
                    end else if (i_plan_status == PHASE_OK) begin
                        w_res.start_exec = 1'b1;
                        n_phase          = '0;
                        n_prog           = '0;
                        w_snap.snap_we   = i_joints_valid;
                        w_snap.have_we   = 1'b1;
                        w_snap.have_val  = i_joints_valid;
                        n_mode           = MODE_EXEC;
                    end else if (i_plan_status == PHASE_FAILED) begin
                        w_res.status     = STATUS_FAILURE;
                        w_res.fail_cause = CAUSE_PLAN_FAILED;
                        n_mode           = MODE_IDLE;
                    end
                end
                MODE_EXEC: begin
                    n_phase = w_phase_tick;
                    n_prog  = w_prog_tick;
                    if (i_exec_status == PHASE_OK) begin
                        w_res.status = STATUS_SUCCESS;
                        n_mode       = MODE_IDLE;
                    end else if (i_exec_status == PHASE_FAILED) begin
                        w_res.status     = STATUS_FAILURE;
                        w_res.fail_cause = CAUSE_EXEC_FAILED;
                        n_mode           = MODE_IDLE;
                    end else begin
                        w_snap.snap_we  = i_joints_valid;
                        w_snap.have_we  = i_joints_valid;
                        w_snap.have_val = 1'b1;
                        if (w_moved) begin
                            n_prog = '0;
                        end
                        if ((CMP_BITS'(w_phase_tick) > CMP_BITS'(i_cfg.exec_grace_ticks)) &&
                            (CMP_BITS'(n_prog) > CMP_BITS'(i_cfg.stall_timeout_ticks))) begin
                            w_res.status     = STATUS_FAILURE;
                            w_res.fail_cause = CAUSE_STALL;
                            w_res.stop_arm   = 1'b1;
                            n_mode           = MODE_IDLE;
                        end
                    end
                end
                default: begin
                    w_res.status     = STATUS_FAILURE;
                    w_res.fail_cause = CAUSE_NOT_ACTIVE;
                    n_mode           = MODE_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_phase <= '0;
            r_prog  <= '0;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_phase <= n_phase;
            r_prog  <= n_prog;
        end
    end

    assign o_result = w_res;
    assign o_snap   = i_fire ? w_snap : '0;
    assign o_mode   = r_mode;

endmodule
